// ===== rtl/seek_arrive_path_steering_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef SEEK_ARRIVE_PATH_STEERING_MACROS_SVH
`define SEEK_ARRIVE_PATH_STEERING_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SAPST_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SAPST_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sapst_pkg.sv =====
package sapst_pkg;

    // Waypoint store geometry.
    localparam int P_DEPTH = 16;
    localparam int P_AW    = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int P_LEN_W = $clog2(P_DEPTH + 1);

    // Request codes of the input word.
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_LOAD  = 2'd1;
    localparam logic [1:0] REQ_PLACE = 2'd2;
    localparam logic [1:0] REQ_SPARE = 2'd3;

    // Configuration register indexes.
    localparam logic [0:0] CFG_STEER_MODE = 1'b0;
    localparam logic [0:0] CFG_PATH_LEN   = 1'b1;

    // Fixed-point steering constants (velocities Q5.16, distances Q24.8).
    localparam logic [31:0] VMAX_Q16    = 32'd786432;
    localparam logic [31:0] FMAX_Q16    = 32'd393216;
    localparam logic [31:0] MASS_DIV    = 32'd10;
    localparam logic [31:0] ARRIVE_NEAR = 32'd12800;
    localparam logic [31:0] RAMP_DIST   = 32'd102400;
    localparam logic [31:0] NODE_NEAR   = 32'd25600;

    // Step counts of the serial arithmetic unit.
    localparam int P_CNT_W = 6;
    localparam logic [P_CNT_W-1:0] MUL_LAST  = P_CNT_W'(31);
    localparam logic [P_CNT_W-1:0] DIV_LAST  = P_CNT_W'(23);
    localparam logic [P_CNT_W-1:0] SQRT_LAST = P_CNT_W'(31);

    typedef enum logic [1:0] {
        AR_MUL,
        AR_DIV,
        AR_SQRT
    } t_ar_op;

    // Request to the arithmetic unit; start is a one-cycle pulse.
    typedef struct packed {
        logic        start;
        t_ar_op      op;
        logic [31:0] a;
        logic [31:0] b;
        logic [63:0] w;
    } t_ar_req;

    // Response; res is valid in the cycle done is high.
    typedef struct packed {
        logic        done;
        logic [63:0] res;
    } t_ar_rsp;

endpackage

// ===== rtl/seek_arrive_path_steering.sv =====
// Seek, arrive and path-following steering of one 3-D agent.
// Input channel (i_valid / o_stall) takes one request word: a tick, a
// waypoint load or an agent placement. Output channel (o_valid / i_stall)
// returns exactly one word per request with position, velocity, the
// targeted waypoint and the path-done flag after that request.
// Configuration is a plain write port (i_cfg_we, i_cfg_addr, i_cfg_data):
// index 0 steer mode, index 1 path length; write only while idle.
// A load, placement or unused request passes straight to the done state
// on acceptance. A tick runs on one shared bit-serial multiply, divide and
// square-root unit (32, 24 and 32 steps per operation); how long it takes
// depends on the ramp and on the clamps taken.
// One request is in work at a time; o_stall is high until its word has
// moved into the output register. The output register holds a word while
// i_stall is high, and the next request can be accepted meanwhile.
// Reset (synchronous, active low) clears position, velocity, waypoint
// index, path-done flag and control state; waypoints stay undefined until loaded.
module seek_arrive_path_steering import sapst_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [0:0]         i_cfg_addr,
    input  logic [4:0]         i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_req_type,
    input  logic [3:0]         i_point_index,
    input  logic signed [31:0] i_coord_x,
    input  logic signed [31:0] i_coord_y,
    input  logic signed [31:0] i_coord_z,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_y,
    output logic signed [31:0] o_pos_z,
    output logic signed [20:0] o_vel_x,
    output logic signed [20:0] o_vel_y,
    output logic signed [20:0] o_vel_z,
    output logic [3:0]         o_target_index,
    output logic               o_path_done
);

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_OFF, S_MAG, S_MAG_W, S_SQ_W, S_MAGD, S_SPD_MW,
        S_SPD_DW, S_SC, S_SC_MW, S_SC_DW, S_SCD, S_STEER, S_POS, S_DONE
    } t_state;

    typedef enum logic [2:0] {
        PH_OFF, PH_STEER, PH_VEL, PH_DES, PH_STCL, PH_D10, PH_VCL
    } t_phase;

    localparam logic signed [33:0] POS_MAX = 34'sh0_7FFF_FFFF;
    localparam logic signed [33:0] POS_MIN = 34'sh3_8000_0000;

    t_state                   r_state;
    t_phase                   r_phase;
    logic                     r_mode;
    logic [4:0]               r_plen;
    logic [P_AW-1:0]          r_node;
    logic                     r_fin;
    logic signed [31:0]       r_pos [3];
    logic signed [20:0]       r_vel [3];
    logic signed [31:0]       r_tgt [3];
    logic signed [31:0]       r_vec [3];
    logic signed [20:0]       r_des [3];
    logic [1:0]               r_k;
    logic [63:0]              r_acc;
    logic [31:0]              r_mag;
    logic [31:0]              r_num;
    logic [31:0]              r_den;
    t_ar_req                  r_req;
    logic                     r_oval;
    logic signed [31:0]       r_opos [3];
    logic signed [20:0]       r_ovel [3];
    logic [3:0]               r_oidx;
    logic                     r_odone;

    t_ar_rsp                  c_rsp;
    logic                     c_acc;
    logic                     c_we;
    logic                     c_re;
    logic [95:0]              c_rdata;
    logic [P_LEN_W-1:0]       c_len;
    logic [P_LEN_W-1:0]       c_lastn;
    logic [P_LEN_W-1:0]       c_np;
    logic [P_AW-1:0]          c_node_cl;
    logic [P_AW-1:0]          c_node_adv;
    logic                     c_arrive;
    logic signed [32:0]       c_d [3];
    logic signed [32:0]       c_dh [3];
    logic                     c_big;
    logic signed [31:0]       c_vk;
    logic [31:0]              c_vabs;
    logic signed [20:0]       c_qmag;
    logic signed [20:0]       c_qs;
    logic [20:0]              c_vm [3];
    logic [12:0]              c_step [3];
    logic signed [33:0]       c_stepx [3];
    logic signed [33:0]       c_psum [3];
    logic signed [31:0]       c_pnew [3];

    // Path bookkeeping, offset and position arithmetic.
    always_comb begin
        c_acc = i_valid && (r_state == S_IDLE);
        if (32'(r_plen) > 32'(P_DEPTH)) begin
            c_len = P_LEN_W'(P_DEPTH);
        end else begin
            c_len = P_LEN_W'(r_plen);
        end
        c_lastn = c_len - P_LEN_W'(1);
        if ((P_LEN_W'(r_node) >= c_len) && (c_len != '0)) begin
            c_node_cl = P_AW'(c_lastn);
        end else begin
            c_node_cl = r_node;
        end
        c_np = P_LEN_W'(r_node) + P_LEN_W'(1);
        c_node_adv = (c_np >= c_len) ? r_node : P_AW'(c_np);
        c_arrive = !r_mode || r_fin;
        c_we = c_acc && (i_req_type == REQ_LOAD) && (32'(i_point_index) < 32'(P_DEPTH));
        c_re = c_acc && (i_req_type == REQ_TICK) && r_mode && (c_len != '0);
        c_big = 1'b0;
        for (int i = 0; i < 3; i++) begin
            c_d[i]  = 33'(r_tgt[i]) - 33'(r_pos[i]);
            c_dh[i] = (c_d[i] + (c_d[i][32] ? 33'sd1 : 33'sd0)) >>> 1;
            if ((c_d[i][32] != c_d[i][31]) || (c_d[i] == 33'sh1_8000_0000)) begin
                c_big = 1'b1;
            end
            c_vm[i]    = r_vel[i][20] ? 21'(-r_vel[i]) : 21'(r_vel[i]);
            c_step[i]  = 13'((22'(c_vm[i]) + 22'd128) >> 8);
            c_stepx[i] = {21'd0, c_step[i]};
            c_psum[i]  = 34'(r_pos[i]) + (r_vel[i][20] ? -c_stepx[i] : c_stepx[i]);
            if (c_psum[i] > POS_MAX) begin
                c_pnew[i] = 32'sh7FFF_FFFF;
            end else if (c_psum[i] < POS_MIN) begin
                c_pnew[i] = 32'sh8000_0000;
            end else begin
                c_pnew[i] = c_psum[i][31:0];
            end
        end
        c_vk   = r_vec[r_k];
        c_vabs = c_vk[31] ? 32'(-c_vk) : 32'(c_vk);
        c_qmag = $signed(c_rsp.res[20:0]);
        c_qs   = c_vk[31] ? -c_qmag : c_qmag;
    end

    // Waypoint store.
    sapst_ram #(
        .W (96),
        .D (P_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (P_AW'(i_point_index)),
        .i_wdata ({i_coord_z, i_coord_y, i_coord_x}),
        .i_re    (c_re),
        .i_raddr (c_node_cl),
        .o_rdata (c_rdata)
    );

    // Shared serial arithmetic unit.
    sapst_arith u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_req),
        .o_rsp   (c_rsp)
    );

    // Tick sequencer, agent state, configuration and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_phase   <= PH_OFF;
            r_mode    <= 1'b0;
            r_plen    <= '0;
            r_node    <= '0;
            r_fin     <= 1'b0;
            r_oval    <= 1'b0;
            r_req     <= '0;
            r_k       <= '0;
            for (int i = 0; i < 3; i++) begin
                r_pos[i] <= '0;
                r_vel[i] <= '0;
            end
        end else begin
            r_req.start <= 1'b0;
            if (r_oval && !i_stall) begin
                r_oval <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_STEER_MODE: r_mode <= i_cfg_data[0];
                    CFG_PATH_LEN:   r_plen <= i_cfg_data;
                    default:        r_mode <= r_mode;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (c_acc) begin
                        r_tgt[0] <= i_coord_x;
                        r_tgt[1] <= i_coord_y;
                        r_tgt[2] <= i_coord_z;
                        r_state  <= S_DONE;
                        case (i_req_type)
                            REQ_TICK: begin
                                if (!r_mode) begin
                                    r_state <= S_OFF;
                                end else if (c_len == '0) begin
                                    for (int i = 0; i < 3; i++) begin
                                        r_tgt[i] <= '0;
                                    end
                                    r_state <= S_OFF;
                                end else begin
                                    r_node <= c_node_cl;
                                    if (P_LEN_W'(c_node_cl) >= c_lastn) begin
                                        r_fin <= 1'b1;
                                    end
                                    r_state <= S_RD;
                                end
                            end
                            REQ_LOAD: begin
                                if (c_we && (i_point_index == 4'd0)) begin
                                    r_node <= '0;
                                end
                            end
                            REQ_PLACE: begin
                                r_pos[0] <= i_coord_x;
                                r_pos[1] <= i_coord_y;
                                r_pos[2] <= i_coord_z;
                                for (int i = 0; i < 3; i++) begin
                                    r_vel[i] <= '0;
                                end
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_RD: begin
                    r_tgt[0] <= c_rdata[31:0];
                    r_tgt[1] <= c_rdata[63:32];
                    r_tgt[2] <= c_rdata[95:64];
                    r_state  <= S_OFF;
                end
                S_OFF: begin
                    for (int i = 0; i < 3; i++) begin
                        r_vec[i] <= c_big ? c_dh[i][31:0] : c_d[i][31:0];
                    end
                    r_phase <= PH_OFF;
                    r_k     <= '0;
                    r_acc   <= '0;
                    r_state <= S_MAG;
                end
                S_MAG: begin
                    r_req.start <= 1'b1;
                    r_req.op    <= AR_MUL;
                    r_req.a     <= c_vabs;
                    r_req.b     <= c_vabs;
                    r_state     <= S_MAG_W;
                end
                S_MAG_W: begin
                    if (c_rsp.done) begin
                        r_acc <= r_acc + c_rsp.res;
                        if (r_k == 2'd2) begin
                            r_req.start <= 1'b1;
                            r_req.op    <= AR_SQRT;
                            r_req.w     <= r_acc + c_rsp.res;
                            r_state     <= S_SQ_W;
                        end else begin
                            r_k     <= r_k + 2'd1;
                            r_state <= S_MAG;
                        end
                    end
                end
                S_SQ_W: begin
                    if (c_rsp.done) begin
                        r_mag   <= c_rsp.res[31:0];
                        r_state <= S_MAGD;
                    end
                end
                S_MAGD: begin
                    r_k <= '0;
                    case (r_phase)
                        PH_OFF: begin
                            if (r_mode && (c_len != '0) && (r_mag <= NODE_NEAR)) begin
                                r_node <= c_node_adv;
                            end
                            r_num   <= VMAX_Q16;
                            r_den   <= r_mag;
                            r_phase <= PH_DES;
                            if (c_arrive && (r_mag <= ARRIVE_NEAR)) begin
                                for (int i = 0; i < 3; i++) begin
                                    r_des[i] <= '0;
                                end
                                r_state <= S_STEER;
                            end else if (c_arrive && (r_mag < RAMP_DIST)) begin
                                r_req.start <= 1'b1;
                                r_req.op    <= AR_MUL;
                                r_req.a     <= r_mag;
                                r_req.b     <= VMAX_Q16;
                                r_state     <= S_SPD_MW;
                            end else if (!c_arrive && (r_mag == '0)) begin
                                for (int i = 0; i < 3; i++) begin
                                    r_des[i] <= '0;
                                end
                                r_state <= S_STEER;
                            end else begin
                                r_state <= S_SC;
                            end
                        end
                        PH_STEER: begin
                            r_state <= S_SC;
                            if (r_mag > FMAX_Q16) begin
                                r_num   <= FMAX_Q16;
                                r_den   <= r_mag;
                                r_phase <= PH_STCL;
                            end else begin
                                r_num   <= 32'd1;
                                r_den   <= MASS_DIV;
                                r_phase <= PH_D10;
                            end
                        end
                        default: begin
                            if (r_mag > VMAX_Q16) begin
                                r_num   <= VMAX_Q16;
                                r_den   <= r_mag;
                                r_phase <= PH_VCL;
                                r_state <= S_SC;
                            end else begin
                                r_state <= S_POS;
                            end
                        end
                    endcase
                end
                S_SPD_MW: begin
                    if (c_rsp.done) begin
                        r_req.start <= 1'b1;
                        r_req.op    <= AR_DIV;
                        r_req.w     <= c_rsp.res;
                        r_req.b     <= RAMP_DIST;
                        r_state     <= S_SPD_DW;
                    end
                end
                S_SPD_DW: begin
                    if (c_rsp.done) begin
                        r_num   <= {8'd0, c_rsp.res[23:0]};
                        r_state <= S_SC;
                    end
                end
                S_SC: begin
                    r_req.start <= 1'b1;
                    r_req.op    <= AR_MUL;
                    r_req.a     <= c_vabs;
                    r_req.b     <= r_num;
                    r_state     <= S_SC_MW;
                end
                S_SC_MW: begin
                    if (c_rsp.done) begin
                        r_req.start <= 1'b1;
                        r_req.op    <= AR_DIV;
                        r_req.w     <= c_rsp.res;
                        r_req.b     <= r_den;
                        r_state     <= S_SC_DW;
                    end
                end
                S_SC_DW: begin
                    if (c_rsp.done) begin
                        case (r_phase)
                            PH_DES:  r_des[r_k] <= c_qs;
                            PH_STCL: r_vec[r_k] <= 32'(c_qs);
                            PH_D10:  r_vel[r_k] <= 21'(22'(r_vel[r_k]) + 22'(c_qs));
                            default: r_vel[r_k] <= c_qs;
                        endcase
                        if (r_k == 2'd2) begin
                            r_state <= S_SCD;
                        end else begin
                            r_k     <= r_k + 2'd1;
                            r_state <= S_SC;
                        end
                    end
                end
                S_SCD: begin
                    r_k <= '0;
                    case (r_phase)
                        PH_DES: begin
                            r_state <= S_STEER;
                        end
                        PH_STCL: begin
                            r_num   <= 32'd1;
                            r_den   <= MASS_DIV;
                            r_phase <= PH_D10;
                            r_state <= S_SC;
                        end
                        PH_D10: begin
                            for (int i = 0; i < 3; i++) begin
                                r_vec[i] <= 32'(r_vel[i]);
                            end
                            r_acc   <= '0;
                            r_phase <= PH_VEL;
                            r_state <= S_MAG;
                        end
                        default: begin
                            r_state <= S_POS;
                        end
                    endcase
                end
                S_STEER: begin
                    for (int i = 0; i < 3; i++) begin
                        r_vec[i] <= 32'(r_des[i]) - 32'(r_vel[i]);
                    end
                    r_k     <= '0;
                    r_acc   <= '0;
                    r_phase <= PH_STEER;
                    r_state <= S_MAG;
                end
                S_POS: begin
                    for (int i = 0; i < 3; i++) begin
                        r_pos[i] <= c_pnew[i];
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_oval || !i_stall) begin
                        for (int i = 0; i < 3; i++) begin
                            r_opos[i] <= r_pos[i];
                            r_ovel[i] <= r_vel[i];
                        end
                        r_oidx  <= 4'(r_node);
                        r_odone <= r_fin;
                        r_oval  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = r_oval;
    assign o_pos_x        = r_opos[0];
    assign o_pos_y        = r_opos[1];
    assign o_pos_z        = r_opos[2];
    assign o_vel_x        = r_ovel[0];
    assign o_vel_y        = r_ovel[1];
    assign o_vel_z        = r_ovel[2];
    assign o_target_index = r_oidx;
    assign o_path_done    = r_odone;

endmodule

// ===== rtl/sapst_ram.sv =====
module sapst_ram #(
    parameter int W = 8,
    parameter int D = 16,
    localparam int AW = (D > 1) ? $clog2(D) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/sapst_arith.sv =====
module sapst_arith import sapst_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_ar_req i_req,
    output t_ar_rsp o_rsp
);

    typedef enum logic {
        A_IDLE,
        A_BUSY
    } t_astate;

    t_astate             r_state;
    t_ar_op              r_op;
    logic [31:0]         r_a;
    logic [31:0]         r_b;
    logic [63:0]         r_x;
    logic [33:0]         r_r;
    logic [31:0]         r_q;
    logic [P_CNT_W-1:0]  r_cnt;
    logic                r_done;

    logic [P_CNT_W-1:0]  c_last;
    logic [32:0]         c_msum;
    logic [32:0]         c_dt;
    logic                c_dge;
    logic [32:0]         c_drem;
    logic [35:0]         c_st;
    logic [35:0]         c_trial;
    logic                c_sge;
    logic [35:0]         c_srem;

    // One step of each operation: shift-add multiply, restoring divide,
    // and a two-bit-per-step integer square root.
    always_comb begin
        case (r_op)
            AR_MUL:  c_last = MUL_LAST;
            AR_DIV:  c_last = DIV_LAST;
            AR_SQRT: c_last = SQRT_LAST;
            default: c_last = MUL_LAST;
        endcase
        c_msum  = 33'(r_x[63:32]) + (r_x[0] ? 33'(r_a) : 33'd0);
        c_dt    = {r_r[31:0], r_x[23]};
        c_dge   = (c_dt >= 33'(r_b));
        c_drem  = c_dge ? (c_dt - 33'(r_b)) : c_dt;
        c_st    = {r_r, r_x[63:62]};
        c_trial = 36'({r_q, 2'b01});
        c_sge   = (c_st >= c_trial);
        c_srem  = c_sge ? (c_st - c_trial) : c_st;
    end

    // Operation sequencer and working registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
            r_done  <= 1'b0;
            r_op    <= AR_MUL;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                A_IDLE: begin
                    if (i_req.start) begin
                        r_op    <= i_req.op;
                        r_a     <= i_req.a;
                        r_b     <= i_req.b;
                        r_cnt   <= '0;
                        r_state <= A_BUSY;
                        case (i_req.op)
                            AR_MUL: begin
                                r_x <= {32'd0, i_req.b};
                            end
                            AR_DIV: begin
                                r_x <= i_req.w;
                                r_r <= {2'b00, i_req.w[55:24]};
                            end
                            default: begin
                                r_x <= i_req.w;
                                r_r <= '0;
                                r_q <= '0;
                            end
                        endcase
                    end
                end
                A_BUSY: begin
                    case (r_op)
                        AR_MUL: begin
                            r_x <= {c_msum, r_x[31:1]};
                        end
                        AR_DIV: begin
                            r_r <= {2'b00, c_drem[31:0]};
                            r_x <= {r_x[63:24], r_x[22:0], c_dge};
                        end
                        default: begin
                            r_r <= c_srem[33:0];
                            r_q <= {r_q[30:0], c_sge};
                            r_x <= {r_x[61:0], 2'b00};
                        end
                    endcase
                    r_cnt <= r_cnt + P_CNT_W'(1);
                    if (r_cnt == c_last) begin
                        r_done  <= 1'b1;
                        r_state <= A_IDLE;
                    end
                end
                default: r_state <= A_IDLE;
            endcase
        end
    end

    // Result selection.
    always_comb begin
        o_rsp.done = r_done;
        case (r_op)
            AR_MUL:  o_rsp.res = r_x;
            AR_DIV:  o_rsp.res = {40'd0, r_x[23:0]};
            AR_SQRT: o_rsp.res = {32'd0, r_q};
            default: o_rsp.res = r_x;
        endcase
    end

endmodule

// ===== rtl/sapst_check.sv =====
`include "seek_arrive_path_steering_macros.svh"

module sapst_check (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_cfg_we,
    input logic [0:0]         i_cfg_addr,
    input logic [4:0]         i_cfg_data,
    input logic               i_valid,
    input logic               o_stall,
    input logic [1:0]         i_req_type,
    input logic [3:0]         i_point_index,
    input logic signed [31:0] i_coord_x,
    input logic signed [31:0] i_coord_y,
    input logic signed [31:0] i_coord_z,
    input logic               o_valid,
    input logic               i_stall,
    input logic signed [31:0] o_pos_x,
    input logic signed [31:0] o_pos_y,
    input logic signed [31:0] o_pos_z,
    input logic signed [20:0] o_vel_x,
    input logic signed [20:0] o_vel_y,
    input logic signed [20:0] o_vel_z,
    input logic [3:0]         o_target_index,
    input logic               o_path_done
);

    // A stalled output word stays valid and unchanged.
    `SAPST_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_pos_x) && $stable(o_vel_x) && $stable(o_target_index), "stalled output word changed")

    // An accepted word keeps the input side busy in the following cycle.
    `SAPST_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && !o_stall, o_stall, "input accepted twice in a row")

    // Every velocity component respects the speed limit.
    `SAPST_ASSERT_NOW(a_vel_bound, i_clk, i_rst_n, o_valid, (o_vel_x <= 21'sd786432) && (o_vel_x >= -21'sd786432) && (o_vel_y <= 21'sd786432) && (o_vel_y >= -21'sd786432) && (o_vel_z <= 21'sd786432) && (o_vel_z >= -21'sd786432), "velocity component above limit")

    // The path-done flag never clears between reported words.
    `SAPST_ASSERT_NOW(a_done_sticky, i_clk, i_rst_n, o_valid && $past(o_valid), !$fell(o_path_done), "path-done flag cleared")

endmodule

bind seek_arrive_path_steering sapst_check u_sapst_check (.*);
